// File: rtl/tts_pkg.sv
`timescale 1ns / 1ps

package tts_pkg;

    localparam int PROG_AW = 3;

    localparam logic [11:0] TICK_MS   = 12'd5;
    localparam logic [9:0]  IDLE_MAX  = 10'd1023;

    localparam logic [1:0] DIR_OFF = 2'd0;
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    localparam logic [1:0] CFG_DARK_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_BRIGHT_LIMIT = 2'd1;
    localparam logic [1:0] CFG_IDLE_LIMIT   = 2'd2;
    localparam logic [1:0] CFG_ITEM_DELAY   = 2'd3;

    typedef enum logic [2:0] {
        OP_TEST_HALT,
        OP_ITEM,
        OP_IDLE_INC,
        OP_IDLE_CHK,
        OP_REL_HALT,
        OP_ADV_HALT,
        OP_ADV_MOTOR,
        OP_END
    } op_t;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_HIT,
        JMP_ALWAYS
    } jmp_t;

    typedef struct packed {
        op_t                  op;
        jmp_t                 jmp;
        logic [PROG_AW-1:0]   target;
    } ctrl_word_t;

    localparam logic [PROG_AW-1:0] STEP_START     = 3'd0;
    localparam logic [PROG_AW-1:0] STEP_REL_HALT  = 3'd4;
    localparam logic [PROG_AW-1:0] STEP_ADV_HALT  = 3'd5;
    localparam logic [PROG_AW-1:0] STEP_END       = 3'd7;

    typedef struct packed {
        logic       halt_button;
        logic [7:0] light_level;
    } in_t;

    typedef struct packed {
        logic [1:0] motor_dir;
        logic       motor_update;
        logic       stopped;
    } out_t;

    // Control program for one tick: trigger pass, then dispatch pass.
    function automatic ctrl_word_t prog_rom(input logic [PROG_AW-1:0] step);
        ctrl_word_t w;
        case (step)
            3'd0:    w = '{op: OP_TEST_HALT, jmp: JMP_HIT,    target: STEP_REL_HALT};
            3'd1:    w = '{op: OP_ITEM,      jmp: JMP_HIT,    target: STEP_ADV_HALT};
            3'd2:    w = '{op: OP_IDLE_INC,  jmp: JMP_HIT,    target: STEP_ADV_HALT};
            3'd3:    w = '{op: OP_IDLE_CHK,  jmp: JMP_ALWAYS, target: STEP_ADV_HALT};
            3'd4:    w = '{op: OP_REL_HALT,  jmp: JMP_NONE,   target: STEP_START};
            3'd5:    w = '{op: OP_ADV_HALT,  jmp: JMP_HIT,    target: STEP_END};
            3'd6:    w = '{op: OP_ADV_MOTOR, jmp: JMP_NONE,   target: STEP_START};
            default: w = '{op: OP_END,       jmp: JMP_NONE,   target: STEP_START};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/timed_task_sequencer_sorter_top.sv
`timescale 1ns / 1ps

// Each input transaction is one scheduler tick and yields exactly one result
// transaction. A tick is run by a microcoded sequencer that walks an eight-word
// control program, one word per clock. The program steps taken are set by which
// trigger condition fires and whether the halt task runs, and one further step
// delivers to the result register. A stopped block goes straight to the
// delivery step. Delivery waits while an earlier result is still held on the
// output. The next tick is accepted once the sequencer is back at rest, even
// while the previous result is still waiting.
// Configuration writes are ignored after the halt task has run.
module timed_task_sequencer_sorter_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tts_pkg::in_t        s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tts_pkg::out_t       m_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [11:0]         cfg_data
);

    logic                       run_reg, run_next;
    logic [tts_pkg::PROG_AW-1:0] step_reg, step_next;
    logic                       halt_reg, halt_next;
    logic [7:0]                 light_reg, light_next;
    logic [7:0]                 dark_reg, dark_next;
    logic [7:0]                 bright_reg, bright_next;
    logic [9:0]                 idle_lim_reg, idle_lim_next;
    logic [11:0]                delay_reg, delay_next;
    logic [11:0]                wait0_reg, wait0_next;
    logic [11:0]                wait1_reg, wait1_next;
    logic                       busy0_reg, busy0_next;
    logic                       busy1_reg, busy1_next;
    logic [1:0]                 dir_reg, dir_next;
    logic                       hold_reg, hold_next;
    logic [9:0]                 idle_reg, idle_next;
    logic                       stopped_reg, stopped_next;
    logic                       update_reg, update_next;
    logic                       m_valid_reg, m_valid_next;
    tts_pkg::out_t              m_data_reg, m_data_next;

    tts_pkg::ctrl_word_t        cw;
    logic                       hit;
    logic                       is_dark;
    logic                       is_bright;
    logic                       out_free;
    logic                       s_fire;

    assign s_ready  = !run_reg;
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign cw       = tts_pkg::prog_rom(step_reg);
    assign is_dark   = light_reg < dark_reg;
    assign is_bright = light_reg > bright_reg;

    always_comb begin
        run_next      = run_reg;
        step_next     = step_reg;
        halt_next     = halt_reg;
        light_next    = light_reg;
        dark_next     = dark_reg;
        bright_next   = bright_reg;
        idle_lim_next = idle_lim_reg;
        delay_next    = delay_reg;
        wait0_next    = wait0_reg;
        wait1_next    = wait1_reg;
        busy0_next    = busy0_reg;
        busy1_next    = busy1_reg;
        dir_next      = dir_reg;
        hold_next     = hold_reg;
        idle_next     = idle_reg;
        stopped_next  = stopped_reg;
        update_next   = update_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        hit           = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_we && !stopped_reg) begin
            case (cfg_index)
                tts_pkg::CFG_DARK_LIMIT:   dark_next     = cfg_data[7:0];
                tts_pkg::CFG_BRIGHT_LIMIT: bright_next   = cfg_data[7:0];
                tts_pkg::CFG_IDLE_LIMIT:   idle_lim_next = cfg_data[9:0];
                tts_pkg::CFG_ITEM_DELAY:   delay_next    = cfg_data;
                default: ;
            endcase
        end

        if (s_fire) begin
            run_next    = 1'b1;
            halt_next   = s_data.halt_button;
            light_next  = s_data.light_level;
            update_next = 1'b0;
            step_next   = stopped_reg ? tts_pkg::STEP_END : tts_pkg::STEP_START;
        end

        if (run_reg) begin
            case (cw.op)
                tts_pkg::OP_TEST_HALT: begin
                    hit = halt_reg;
                end
                tts_pkg::OP_ITEM: begin
                    hit = !hold_reg && (is_dark || is_bright);
                    if (hit) begin
                        dir_next  = is_dark ? tts_pkg::DIR_FWD : tts_pkg::DIR_REV;
                        hold_next = 1'b1;
                        if (!busy1_reg) begin
                            busy1_next = 1'b1;
                            wait1_next = delay_reg;
                        end
                    end
                end
                tts_pkg::OP_IDLE_INC: begin
                    hit = hold_reg;
                    if (!hold_reg && idle_reg != tts_pkg::IDLE_MAX) begin
                        idle_next = idle_reg + 10'd1;
                    end
                end
                tts_pkg::OP_IDLE_CHK: begin
                    hit = idle_reg > idle_lim_reg;
                    if (hit) begin
                        dir_next  = tts_pkg::DIR_OFF;
                        hold_next = 1'b1;
                        if (!busy1_reg) begin
                            busy1_next = 1'b1;
                            wait1_next = tts_pkg::TICK_MS;
                        end
                    end
                end
                tts_pkg::OP_REL_HALT: begin
                    if (!busy0_reg) begin
                        busy0_next = 1'b1;
                        wait0_next = tts_pkg::TICK_MS;
                    end
                end
                tts_pkg::OP_ADV_HALT: begin
                    hit = busy0_reg && (wait0_reg <= tts_pkg::TICK_MS);
                    if (hit) begin
                        busy0_next   = 1'b0;
                        wait0_next   = '0;
                        stopped_next = 1'b1;
                    end else if (busy0_reg) begin
                        wait0_next = wait0_reg - tts_pkg::TICK_MS;
                    end
                end
                tts_pkg::OP_ADV_MOTOR: begin
                    hit = busy1_reg && (wait1_reg <= tts_pkg::TICK_MS);
                    if (hit) begin
                        busy1_next  = 1'b0;
                        wait1_next  = '0;
                        update_next = 1'b1;
                        hold_next   = 1'b0;
                        idle_next   = '0;
                    end else if (busy1_reg) begin
                        wait1_next = wait1_reg - tts_pkg::TICK_MS;
                    end
                end
                default: begin
                    if (out_free) begin
                        m_valid_next             = 1'b1;
                        m_data_next.motor_dir    = dir_reg;
                        m_data_next.motor_update = update_reg;
                        m_data_next.stopped      = stopped_reg;
                        run_next                 = 1'b0;
                    end
                end
            endcase

            if (cw.op != tts_pkg::OP_END) begin
                if (cw.jmp == tts_pkg::JMP_ALWAYS || (cw.jmp == tts_pkg::JMP_HIT && hit)) begin
                    step_next = cw.target;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg      <= 1'b0;
            step_reg     <= tts_pkg::STEP_START;
            dark_reg     <= 8'd30;
            bright_reg   <= 8'd40;
            idle_lim_reg <= 10'd250;
            delay_reg    <= 12'd500;
            wait0_reg    <= '0;
            wait1_reg    <= '0;
            busy0_reg    <= 1'b0;
            busy1_reg    <= 1'b0;
            dir_reg      <= tts_pkg::DIR_OFF;
            hold_reg     <= 1'b0;
            idle_reg     <= '0;
            stopped_reg  <= 1'b0;
            update_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            run_reg      <= run_next;
            step_reg     <= step_next;
            dark_reg     <= dark_next;
            bright_reg   <= bright_next;
            idle_lim_reg <= idle_lim_next;
            delay_reg    <= delay_next;
            wait0_reg    <= wait0_next;
            wait1_reg    <= wait1_next;
            busy0_reg    <= busy0_next;
            busy1_reg    <= busy1_next;
            dir_reg      <= dir_next;
            hold_reg     <= hold_next;
            idle_reg     <= idle_next;
            stopped_reg  <= stopped_next;
            update_reg   <= update_next;
            m_valid_reg  <= m_valid_next;
        end
        halt_reg   <= halt_next;
        light_reg  <= light_next;
        m_data_reg <= m_data_next;
    end

    a_stopped_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("Stopped flag was cleared.");

    a_no_motor_after_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.stopped |-> !m_data.motor_update)
        else $error("Motor update reported on a stopped transaction.");

    a_halt_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(stopped_reg) |-> !busy0_reg)
        else $error("Halt task still pending after it ran.");

endmodule
